>>> rtl/core/loglog_counter_edge_merge_unit_assert.svh
// Assertion macros shared by the edge-merge unit. All sample on i_clk and
// are disabled while i_rst_n is low.
`ifndef LOGLOG_COUNTER_EDGE_MERGE_UNIT_ASSERT_SVH
`define LOGLOG_COUNTER_EDGE_MERGE_UNIT_ASSERT_SVH

// same-cycle implication
`define LLCEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LLCEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/llcem_pkg.sv
package llcem_pkg;

    localparam int VERTEX_COUNT    = 1024;
    localparam int MAX_WORDS       = 4;
    localparam int FIELDS_PER_WORD = 10;
    localparam int FIELD_BITS      = 6;
    localparam int WORD_BITS       = FIELDS_PER_WORD * FIELD_BITS;
    localparam int MARK_BITS       = 16;
    localparam int CMD_BITS        = 2;
    localparam int WPV_BITS        = 3;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 16;

    localparam int VERTEX_BITS   = $clog2(VERTEX_COUNT);
    localparam int WORD_SEL_BITS = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int ADDR_BITS     = VERTEX_BITS + WORD_SEL_BITS;
    localparam int WCNT_BITS     = $clog2(MAX_WORDS + 1);

    localparam logic [CMD_BITS-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SYNC = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_EDGE = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_READ = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WORDS_PER_VERTEX = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CURRENT_ROUND    = 1'd1;

    // controller -> datapath
    typedef struct packed {
        logic                     capture;
        logic                     clr_we;
        logic [VERTEX_BITS-1:0]   clr_addr;
        logic                     step_rd;
        logic [WORD_SEL_BITS-1:0] rd_word;
        logic                     step_wr;
        logic [WORD_SEL_BITS-1:0] wr_word;
        logic                     mark_rd;
        logic                     load_we;
        logic                     finish;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [WCNT_BITS-1:0] active_words;
    } t_dp_status;

    function automatic logic [WORD_BITS-1:0] field_max(
        input logic [WORD_BITS-1:0] inc,
        input logic [WORD_BITS-1:0] base
    );
        logic [WORD_BITS-1:0] res;
        res = base;
        for (int f = 0; f < FIELDS_PER_WORD; f++) begin
            if (inc[f*FIELD_BITS +: FIELD_BITS] > base[f*FIELD_BITS +: FIELD_BITS])
                res[f*FIELD_BITS +: FIELD_BITS] = inc[f*FIELD_BITS +: FIELD_BITS];
        end
        return res;
    endfunction

    function automatic logic field_grew(
        input logic [WORD_BITS-1:0] inc,
        input logic [WORD_BITS-1:0] base
    );
        logic g;
        g = 1'b0;
        for (int f = 0; f < FIELDS_PER_WORD; f++) begin
            if (inc[f*FIELD_BITS +: FIELD_BITS] > base[f*FIELD_BITS +: FIELD_BITS])
                g = 1'b1;
        end
        return g;
    endfunction

endpackage

>>> rtl/core/llcem_datapath.sv
module llcem_datapath
    import llcem_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_ctl,
    output t_dp_status                o_status,
    input  logic [CMD_BITS-1:0]       i_cmd,
    input  logic [VERTEX_BITS-1:0]    i_source_vertex,
    input  logic [VERTEX_BITS-1:0]    i_dest_vertex,
    input  logic [WORD_SEL_BITS-1:0]  i_word_index,
    input  logic [WORD_BITS-1:0]      i_counter_word,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                      o_changed,
    output logic [MARK_BITS-1:0]      o_mark_value
);

    logic [WORD_BITS-1:0] cur_mem  [VERTEX_COUNT*MAX_WORDS];
    logic [WORD_BITS-1:0] next_mem [VERTEX_COUNT*MAX_WORDS];
    logic [MARK_BITS-1:0] mark_mem [VERTEX_COUNT];

    logic [WPV_BITS-1:0]      r_wpv;
    logic [MARK_BITS-1:0]     r_round;
    logic [CMD_BITS-1:0]      r_cmd;
    logic [VERTEX_BITS-1:0]   r_src;
    logic [VERTEX_BITS-1:0]   r_dst;
    logic [WORD_SEL_BITS-1:0] r_widx;
    logic [WORD_BITS-1:0]     r_word;
    logic [WORD_BITS-1:0]     r_cur_q;
    logic [WORD_BITS-1:0]     r_next_q;
    logic [MARK_BITS-1:0]     r_mark_q;
    logic                     r_grew;
    logic                     r_changed;
    logic [MARK_BITS-1:0]     r_mark_out;

    logic [VERTEX_BITS-1:0]   mark_vtx;
    logic [VERTEX_BITS-1:0]   next_vtx;
    logic [ADDR_BITS-1:0]     next_rd_addr;
    logic [ADDR_BITS-1:0]     next_wr_addr;
    logic [ADDR_BITS-1:0]     cur_rd_addr;
    logic [ADDR_BITS-1:0]     cur_wr_addr;
    logic [WORD_BITS-1:0]     next_wr_data;
    logic                     next_we;
    logic                     next_re;
    logic                     cur_we;
    logic                     cur_re;
    logic                     is_edge;
    logic                     is_sync;
    logic                     changed;
    logic [WCNT_BITS-1:0]     active_words;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpv   <= WPV_BITS'(1);
            r_round <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WORDS_PER_VERTEX)
                r_wpv <= i_cfg_data[WPV_BITS-1:0];
            else if (i_cfg_index == CFG_CURRENT_ROUND)
                r_round <= i_cfg_data[MARK_BITS-1:0];
        end
    end

    always_comb begin
        if (r_wpv == '0)
            active_words = WCNT_BITS'(1);
        else if (WCNT_BITS'(r_wpv) > WCNT_BITS'(MAX_WORDS))
            active_words = WCNT_BITS'(MAX_WORDS);
        else
            active_words = WCNT_BITS'(r_wpv);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd  <= i_cmd;
            r_src  <= i_source_vertex;
            r_dst  <= i_dest_vertex;
            r_widx <= i_word_index;
            r_word <= i_counter_word;
        end
    end

    assign is_edge  = (r_cmd == CMD_EDGE);
    assign is_sync  = (r_cmd == CMD_SYNC);
    assign mark_vtx = is_edge ? r_dst : r_src;
    assign next_vtx = is_edge ? r_dst : r_src;

    assign o_status.cmd          = r_cmd;
    assign o_status.active_words = active_words;

    // next store: written by load and by merge, read by sync and merge
    assign next_rd_addr = {next_vtx, i_ctl.rd_word};
    assign next_re      = i_ctl.step_rd && (is_edge || is_sync);
    always_comb begin
        if (i_ctl.load_we) begin
            next_wr_addr = {r_src, r_widx};
            next_wr_data = r_word;
        end else begin
            next_wr_addr = {r_dst, i_ctl.wr_word};
            next_wr_data = field_max(r_cur_q, r_next_q);
        end
    end
    assign next_we = i_ctl.load_we || (i_ctl.step_wr && is_edge);

    always_ff @(posedge i_clk) begin
        if (next_we)
            next_mem[next_wr_addr] <= next_wr_data;
        if (next_re)
            r_next_q <= next_mem[next_rd_addr];
    end

    // current store: written by sync, read by merge
    assign cur_rd_addr = {r_src, i_ctl.rd_word};
    assign cur_wr_addr = {r_src, i_ctl.wr_word};
    assign cur_re      = i_ctl.step_rd && is_edge;
    assign cur_we      = i_ctl.step_wr && is_sync;

    always_ff @(posedge i_clk) begin
        if (cur_we)
            cur_mem[cur_wr_addr] <= r_next_q;
        if (cur_re)
            r_cur_q <= cur_mem[cur_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture)
            r_grew <= 1'b0;
        else if (i_ctl.step_wr && is_edge && field_grew(r_cur_q, r_next_q))
            r_grew <= 1'b1;
    end

    assign changed = r_grew && (r_mark_q != r_round);

    // marks: cleared by the sweep after reset, set on change
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_we)
            mark_mem[i_ctl.clr_addr] <= '0;
        else if (i_ctl.finish && changed)
            mark_mem[mark_vtx] <= r_round;
        if (i_ctl.mark_rd)
            r_mark_q <= mark_mem[mark_vtx];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_changed  <= changed;
            r_mark_out <= changed ? r_round : r_mark_q;
        end
    end

    assign o_changed    = r_changed;
    assign o_mark_value = r_mark_out;

endmodule

>>> rtl/core/llcem_ctrl.sv
`include "loglog_counter_edge_merge_unit_assert.svh"

module llcem_ctrl
    import llcem_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_ctl
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_MARK  = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [WCNT_BITS-1:0]   r_cnt;
    logic [WCNT_BITS-1:0]   n_cnt;
    logic [VERTEX_BITS-1:0] r_clr_cnt;
    logic                   r_out_valid;
    logic                   accept;
    logic                   out_free;
    logic                   word_cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign word_cmd    = i_status.cmd inside {CMD_EDGE, CMD_SYNC};

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_ctl          = '0;
        o_ctl.clr_addr = r_clr_cnt;
        o_ctl.rd_word  = r_cnt[WORD_SEL_BITS-1:0];
        o_ctl.wr_word  = r_cnt[WORD_SEL_BITS-1:0] - WORD_SEL_BITS'(1);
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_we = 1'b1;
                if (r_clr_cnt == VERTEX_BITS'(VERTEX_COUNT - 1))
                    n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_ctl.capture = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_STEP;
                end
            end
            S_STEP: begin
                o_ctl.mark_rd = 1'b1;
                if (word_cmd) begin
                    // read word cnt while writing back word cnt-1
                    o_ctl.step_rd = (r_cnt < i_status.active_words);
                    o_ctl.step_wr = (r_cnt != '0);
                    n_cnt         = r_cnt + WCNT_BITS'(1);
                    if (r_cnt == i_status.active_words)
                        n_state = S_MARK;
                end else begin
                    o_ctl.load_we = (i_status.cmd == CMD_LOAD);
                    n_state       = S_MARK;
                end
            end
            S_MARK: begin
                if (out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_CLEAR)
                r_clr_cnt <= r_clr_cnt + VERTEX_BITS'(1);
            if (o_ctl.finish)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    `LLCEM_ASSERT_NOW(a_finish_slot_free, o_ctl.finish, !r_out_valid || i_out_ready, "result overwrote a pending transaction")
    `LLCEM_ASSERT_NEXT(a_accept_to_step, accept, r_state == S_STEP, "accepted transaction did not start")
    `LLCEM_ASSERT_NOW(a_wr_in_range, o_ctl.step_wr, (r_cnt != '0) && (r_cnt <= i_status.active_words), "word write-back outside active words")
    `LLCEM_ASSERT_NEXT(a_clear_done, (r_state == S_CLEAR) && (r_clr_cnt == VERTEX_BITS'(VERTEX_COUNT - 1)), r_state == S_IDLE, "mark clear sweep did not end")

endmodule

>>> rtl/core/loglog_counter_edge_merge_unit.sv
// LogLog counter edge-merge unit. One transaction is taken at a time. With the
// output free, load and read-mark pass through the step and mark states and then
// load their result; sync and edge merge step through the active word count
// (words_per_vertex clamped to 1..4), one counter word per cycle through the
// read and write ports of the counter stores, with the mark update of an edge
// merge in the mark state. The result sits in an output register; the next
// transaction is accepted the cycle after the result is loaded, and a result
// still waiting on the output holds the unit in its mark state. After reset a
// clearing pass zeroes the 1024 eccentricity marks, during which no transaction
// is accepted (configuration writes are taken as always). Configuration must be
// written only while the unit is idle.
module loglog_counter_edge_merge_unit
    import llcem_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [CMD_BITS-1:0]       i_cmd,
    input  logic [VERTEX_BITS-1:0]    i_source_vertex,
    input  logic [VERTEX_BITS-1:0]    i_dest_vertex,
    input  logic [WORD_SEL_BITS-1:0]  i_word_index,
    input  logic [WORD_BITS-1:0]      i_counter_word,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_changed,
    output logic [MARK_BITS-1:0]      o_mark_value,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_dp_cmd    ctl;
    t_dp_status status;

    llcem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_ctl       (ctl)
    );

    llcem_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_status        (status),
        .i_cmd           (i_cmd),
        .i_source_vertex (i_source_vertex),
        .i_dest_vertex   (i_dest_vertex),
        .i_word_index    (i_word_index),
        .i_counter_word  (i_counter_word),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_changed       (o_changed),
        .o_mark_value    (o_mark_value)
    );

endmodule
